/* hdl/abti_pkg.sv */
// Shared constants and types for the array binary tree insert block.
package abti_pkg;

  localparam int unsigned SLOTS   = 32;
  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned CHILD_W = IDX_W + 2;
  localparam int unsigned EXT_W   = 12;
  localparam int unsigned VAL_W   = 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_CHILD
  } state_e;

  typedef enum logic [1:0] {
    OP_SET_ROOT  = 2'd0,
    OP_INS_LEFT  = 2'd1,
    OP_INS_RIGHT = 2'd2,
    OP_READ      = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    STS_OK           = 3'd0,
    STS_ROOT_EXISTS  = 3'd1,
    STS_CHILD_EXISTS = 3'd2,
    STS_NO_PARENT    = 3'd3,
    STS_RANGE        = 3'd4,
    STS_INVALID      = 3'd5
  } status_e;

endpackage

/* hdl/array_binary_tree_insert.sv */
// Set root and rejected items finish in idle; a read passes ST_READ; an insert scans, then ST_CHILD.
// An insert scans the slot memory one entry per cycle from slot 0 through the single
// read port. Busy drops as the result appears; no new item is taken while busy is high.
// After reset a clearing pass writes zero to all SLOTS entries (busy high).
// Each result is shown for one cycle with done_o; the receiver cannot stall.
module array_binary_tree_insert
  import abti_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        opcode_i,
  input  logic [VAL_W-1:0]  node_value_i,
  input  logic [VAL_W-1:0]  parent_key_i,
  input  logic [4:0]        slot_index_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic [VAL_W-1:0]  slot_value_o,
  output logic [4:0]        position_o,
  output logic              tree_present_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               chk_q, chk_d;
  logic [IDX_W-1:0]   chk_addr_q, chk_addr_d;
  opcode_e            op_q, op_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [VAL_W-1:0]   key_q, key_d;
  logic [4:0]         idx_q, idx_d;
  logic [CHILD_W-1:0] child_q, child_d;
  logic               root_q, root_d;
  logic               done_q, done_d;
  status_e            status_q, status_d;
  logic [VAL_W-1:0]   value_q, value_d;
  logic [4:0]         pos_q, pos_d;
  logic               present_q, present_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [VAL_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [VAL_W-1:0]   ram_rdata;

  opcode_e            op_in;
  logic               accept;
  logic               rd_range;
  logic [EXT_W-1:0]   idx_ext;
  logic               issue;
  logic               match;
  logic               last;
  logic [CHILD_W-1:0] child_w;
  logic [EXT_W-1:0]   child_ext;
  logic [EXT_W-1:0]   child_q_ext;
  logic               child_range;

  assign op_in       = opcode_e'(opcode_i);
  assign accept      = start && (state_q == ST_IDLE);
  assign busy        = (state_q != ST_IDLE);
  assign idx_ext     = EXT_W'(slot_index_i);
  assign rd_range    = (idx_ext >= EXT_W'(SLOTS));
  assign issue       = (cnt_q < CNT_W'(SLOTS));
  assign match       = chk_q && (ram_rdata == key_q);
  assign last        = chk_q && (chk_addr_q == IDX_W'(SLOTS - 1));
  // Left child sits at 2i+1, right child at 2i+2.
  assign child_w     = {1'b0, chk_addr_q, 1'b0}
                     + ((op_q == OP_INS_LEFT) ? CHILD_W'(1) : CHILD_W'(2));
  assign child_ext   = EXT_W'(child_w);
  assign child_q_ext = EXT_W'(child_q);
  assign child_range = (child_ext >= EXT_W'(SLOTS));

  abti_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == CNT_W'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_SET_ROOT: state_d = ST_IDLE;
            OP_INS_LEFT, OP_INS_RIGHT: begin
              if (node_value_i != '0 && parent_key_i != '0) begin
                state_d = ST_SCAN;
              end
            end
            OP_READ: begin
              if (!rd_range) begin
                state_d = ST_READ;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_d = ST_IDLE;
      ST_SCAN: begin
        if (match) begin
          state_d = child_range ? ST_IDLE : ST_CHILD;
        end else if (last) begin
          state_d = ST_IDLE;
        end
      end
      ST_CHILD: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory control and result registers.
  always_comb begin
    cnt_d      = cnt_q;
    chk_d      = 1'b0;
    chk_addr_d = chk_addr_q;
    op_d       = op_q;
    val_d      = val_q;
    key_d      = key_q;
    idx_d      = idx_q;
    child_d    = child_q;
    root_d     = root_q;
    done_d     = 1'b0;
    status_d   = status_q;
    value_d    = '0;
    pos_d      = '0;
    present_d  = present_q;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q[IDX_W-1:0];
    ram_wdata  = '0;
    ram_raddr  = cnt_q[IDX_W-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + CNT_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          op_d  = op_in;
          val_d = node_value_i;
          key_d = parent_key_i;
          idx_d = slot_index_i;
          cnt_d = '0;
          ram_raddr = idx_ext[IDX_W-1:0];
          unique case (op_in)
            OP_SET_ROOT: begin
              done_d = 1'b1;
              if (node_value_i == '0) begin
                status_d = STS_INVALID;
              end else if (root_q) begin
                status_d = STS_ROOT_EXISTS;
              end else begin
                status_d  = STS_OK;
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = node_value_i;
                root_d    = 1'b1;
              end
              present_d = root_d;
            end
            OP_INS_LEFT, OP_INS_RIGHT: begin
              if (node_value_i == '0 || parent_key_i == '0) begin
                done_d    = 1'b1;
                status_d  = STS_INVALID;
                present_d = root_q;
              end
            end
            OP_READ: begin
              if (rd_range) begin
                done_d    = 1'b1;
                status_d  = STS_RANGE;
                present_d = root_q;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        done_d    = 1'b1;
        status_d  = STS_OK;
        value_d   = ram_rdata;
        pos_d     = idx_q;
        present_d = root_q;
      end
      ST_SCAN: begin
        if (match) begin
          child_d   = child_w;
          ram_raddr = child_w[IDX_W-1:0];
          if (child_range) begin
            done_d    = 1'b1;
            status_d  = STS_RANGE;
            present_d = root_q;
          end
        end else if (last) begin
          done_d    = 1'b1;
          status_d  = STS_NO_PARENT;
          present_d = root_q;
        end else begin
          chk_d      = issue;
          chk_addr_d = cnt_q[IDX_W-1:0];
          if (issue) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      ST_CHILD: begin
        done_d    = 1'b1;
        present_d = root_q;
        if (ram_rdata != '0) begin
          status_d = STS_CHILD_EXISTS;
        end else begin
          status_d  = STS_OK;
          ram_we    = 1'b1;
          ram_waddr = child_q[IDX_W-1:0];
          ram_wdata = val_q;
          pos_d     = child_q_ext[4:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      chk_q     <= 1'b0;
      root_q    <= 1'b0;
      done_q    <= 1'b0;
      present_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_q     <= chk_d;
      root_q    <= root_d;
      done_q    <= done_d;
      present_q <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_addr_q <= chk_addr_d;
    op_q       <= op_d;
    val_q      <= val_d;
    key_q      <= key_d;
    idx_q      <= idx_d;
    child_q    <= child_d;
    status_q   <= status_d;
    value_q    <= value_d;
    pos_q      <= pos_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign slot_value_o   = value_q;
  assign position_o     = pos_q;
  assign tree_present_o = present_q;

endmodule

/* hdl/abti_ram.sv */
// Generic single-clock RAM with one write port and a registered read port.
module abti_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
